// ----- rtl/fuzzy_scheduled_lqr_drive_macros.svh -----
// Assertion macros for the drive pipeline; used by fsld_out.
// No dependencies; included by the files that carry assertions.
`ifndef FUZZY_SCHEDULED_LQR_DRIVE_MACROS_SVH
`define FUZZY_SCHEDULED_LQR_DRIVE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FSLD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("fsld assertion failed");
// next-cycle implication
`define FSLD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("fsld assertion failed");
`else
`define FSLD_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define FSLD_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ----- rtl/fsld_pkg.sv -----
// Types, constants and the target-tilt table of the fuzzy scheduled LQR drive.
// No dependencies; imported by every module of the block.
package fsld_pkg;

	// state fixed point format
	localparam int F = 12;                 // STATE_FRAC_BITS, range 8..16
	localparam int VOLT_FRAC = 8;          // drive is volts * 2^8
	localparam int REG_W = 12;             // config register width
	localparam int DRV_W = 13;

	// fuzzy schedule breakpoints in degrees, weights in twentieths
	localparam logic [7:0] BP_LOW = 8'd115;
	localparam logic [7:0] BP_MID = 8'd135;
	localparam logic [7:0] BP_HIGH = 8'd155;
	localparam int WH_W = 5;
	localparam logic [WH_W-1:0] W_FULL = WH_W'(20);

	// target tilt: (500 + wm)/40 degrees, to radians via pi/180 in Q30
	localparam longint DEG2RAD_Q30 = 64'sd18740330;
	localparam longint TGT_BASE = 64'sd500;
	localparam int TGT_W = F - 1;
	typedef logic [20:0][TGT_W-1:0] tgt_lut_t;

	// datapath widths
	localparam int ERR_W = 17;
	localparam int KT_W = 11;
	localparam int PW = 21;                // wh * 16-bit state
	localparam int P_W = 28;               // kt * err
	localparam int R_W = 33;               // gain sum of the high set terms
	localparam int S_W = 38;               // full weighted sum
	localparam int MAG_W = S_W - 1;

	// rounding divide by 20000 * 2^F = 625 * 2^(F+5)
	localparam int DEN_SHIFT = F + 5;
	localparam int NUM_W = MAG_W + VOLT_FRAC + 1;
	localparam int N1_W = NUM_W - DEN_SHIFT;
	localparam int K_SHIFT = N1_W + 10;
	localparam int RC_W = K_SHIFT - 9;
	localparam int PROD_W = N1_W + RC_W;
	localparam int Q_W = PROD_W - K_SHIFT;
	localparam int M_W = Q_W + 1;
	localparam longint DEN_ODD = 64'sd625;
	localparam longint RECIP_L = ((longint'(1) <<< K_SHIFT) + DEN_ODD - 1) / DEN_ODD;
	localparam logic [RC_W-1:0] RECIP = RC_W'(RECIP_L);
	localparam logic [NUM_W-1:0] ROUND_ADD = NUM_W'(longint'(10000) <<< F);

	// config register indexes and reset values
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_KICK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VMAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DZONE = 2'd2;
	localparam logic [REG_W-1:0] KICK_RST = 12'd205;
	localparam logic [REG_W-1:0] VMAX_RST = 12'd2560;
	localparam logic [REG_W-1:0] DZONE_RST = 12'd20;

	typedef struct packed {
		logic [7:0]         servo_angle;
		logic signed [15:0] tilt;
		logic signed [15:0] tilt_rate;
		logic signed [15:0] position;
		logic signed [15:0] velocity;
	} sample_t;

	typedef struct packed {
		logic signed [DRV_W-1:0] drive_voltage;
		logic                    clipped;
	} result_t;

	typedef struct packed {
		logic [REG_W-1:0] kick;
		logic [REG_W-1:0] vmax;
		logic [REG_W-1:0] dzone;
	} cfg_t;

	// scheduler stage word
	typedef struct packed {
		logic signed [ERR_W-1:0] err;
		logic [KT_W-1:0]         kt;
		logic [WH_W-1:0]         wh;
		logic signed [PW-1:0]    p_rate;
		logic signed [PW-1:0]    p_pos;
		logic signed [PW-1:0]    p_vel;
	} sched_t;

	// sum stage word
	typedef struct packed {
		logic signed [S_W-1:0] s;
		logic                  dz;
	} sum_t;

	// target tilt per mid weight, rounded to nearest
	localparam longint TGT_DEN = longint'(40) <<< 30;
	localparam longint TGT_HALF = TGT_DEN >>> 1;
	localparam longint TGT_STEP = DEG2RAD_Q30 <<< F;
	localparam tgt_lut_t TARGET_LUT = {
		TGT_W'(((TGT_BASE + 20) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 19) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 18) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 17) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 16) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 15) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 14) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 13) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 12) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 11) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 10) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 9) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 8) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 7) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 6) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 5) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 4) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 3) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 2) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 1) * TGT_STEP + TGT_HALF) / TGT_DEN),
		TGT_W'(((TGT_BASE + 0) * TGT_STEP + TGT_HALF) / TGT_DEN)
	};

endpackage

// ----- rtl/fsld_sched.sv -----
// Stages 1-2: fuzzy memberships, target tilt, tilt error, gains, high-set products.
// Depends on fsld_pkg.
module fsld_sched
	import fsld_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_vld,
	input  sample_t sample,
	output logic    v_s2,
	output sched_t  sched_s2
);

	logic            v_s1;
	sample_t         smp_s1;
	logic [WH_W-1:0] wm_s1;
	logic [WH_W-1:0] wh_s1;
	logic [WH_W-1:0] wm_d;
	logic [WH_W-1:0] wh_d;
	logic [TGT_W-1:0] target;
	sched_t          sched_d;

	// triangular memberships; low weight is implied by the other two
	always_comb begin
		wm_d = '0;
		wh_d = '0;
		if (sample.servo_angle <= BP_LOW) begin
			wm_d = '0;
		end else if (sample.servo_angle <= BP_MID) begin
			wm_d = WH_W'(sample.servo_angle - BP_LOW);
		end else if (sample.servo_angle <= BP_HIGH) begin
			wm_d = WH_W'(BP_HIGH - sample.servo_angle);
			wh_d = WH_W'(sample.servo_angle - BP_MID);
		end else begin
			wh_d = W_FULL;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
		end
	end

	// stage 2: error, gain and products of the high-set weight
	always_comb begin
		target = TARGET_LUT[wm_s1];
		sched_d.err = ERR_W'(smp_s1.tilt) - ERR_W'(signed'({1'b0, target}));
		sched_d.kt = KT_W'(1000) + KT_W'(wm_s1) * KT_W'(10) + KT_W'(wh_s1) * KT_W'(20);
		sched_d.wh = wh_s1;
		sched_d.p_rate = PW'(signed'({1'b0, wh_s1})) * PW'(smp_s1.tilt_rate);
		sched_d.p_pos = PW'(signed'({1'b0, wh_s1})) * PW'(smp_s1.position);
		sched_d.p_vel = PW'(signed'({1'b0, wh_s1})) * PW'(smp_s1.velocity);
	end

	// payload
	always_ff @(posedge clk) begin
		smp_s1 <= sample;
		wm_s1 <= wm_d;
		wh_s1 <= wh_d;
		sched_s2 <= sched_d;
	end

endmodule

// ----- rtl/fsld_sum.sv -----
// Stages 3-4: gain products, deadzone test, exact weighted sum.
// Depends on fsld_pkg.
module fsld_sum
	import fsld_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   v_s2,
	input  sched_t sched_s2,
	output logic   v_s4,
	output sum_t   sum_s4
);

	localparam logic signed [R_W-1:0] C_RATE = R_W'(3000);
	localparam logic signed [R_W-1:0] C_POS = R_W'(100);
	localparam logic signed [R_W-1:0] C_VEL = R_W'(1000);
	localparam logic signed [R_W-1:0] C_OFS = R_W'(longint'(90) <<< F);
	localparam logic signed [S_W-1:0] C_TILT = S_W'(1000);

	logic                  v_s3;
	logic signed [P_W-1:0] p_kt_s3;
	logic signed [R_W-1:0] r_s3;
	logic                  dz_s3;
	logic [ERR_W-1:0]      aerr;
	logic signed [R_W-1:0] r_d;

	// high-set terms and the 0.03 tilt-rate offset
	always_comb begin
		r_d = R_W'(sched_s2.p_rate) * C_RATE + R_W'(sched_s2.p_pos) * C_POS
			+ R_W'(sched_s2.p_vel) * C_VEL + R_W'(signed'({1'b0, sched_s2.wh})) * C_OFS;
		aerr = sched_s2.err[ERR_W-1] ? ERR_W'(-sched_s2.err) : ERR_W'(sched_s2.err);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 3: tilt gain product; stage 4: full sum
	always_ff @(posedge clk) begin
		p_kt_s3 <= P_W'(signed'({1'b0, sched_s2.kt})) * P_W'(sched_s2.err);
		r_s3 <= r_d;
		dz_s3 <= (aerr < ERR_W'(cfg.dzone));
		sum_s4.s <= S_W'(p_kt_s3) * C_TILT + S_W'(r_s3);
		sum_s4.dz <= dz_s3;
	end

endmodule

// ----- rtl/fsld_out.sv -----
// Stages 5-7 and output register: rounding divide, friction kick, clamp, deadzone.
// Depends on fsld_pkg and fuzzy_scheduled_lqr_drive_macros.svh.
`include "fuzzy_scheduled_lqr_drive_macros.svh"
module fsld_out
	import fsld_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    v_s4,
	input  sum_t    sum_s4,
	output logic    done,
	output result_t result
);

	logic                v_s5, v_s6, v_s7;
	logic                neg_s5, neg_s6, neg_s7;
	logic                zero_s5, zero_s6;
	logic                dz_s5, dz_s6, dz_s7;
	logic [N1_W-1:0]     n1_s5;
	logic [PROD_W-1:0]   prod_s6;
	logic [REG_W-1:0]    mag_s7;
	logic                clip_s7;
	logic [MAG_W-1:0]    mag_abs;
	logic [NUM_W-1:0]    num;
	logic [Q_W-1:0]      q;
	logic [M_W-1:0]      m;
	logic                clip_d;
	logic [DRV_W-1:0]    drv_mag;

	// stage 5: magnitude, add half the divisor, drop the power of two
	always_comb begin
		mag_abs = sum_s4.s[S_W-1] ? MAG_W'(-sum_s4.s) : MAG_W'(sum_s4.s);
		num = {1'b0, mag_abs, {VOLT_FRAC{1'b0}}} + ROUND_ADD;
	end

	// stage 7: quotient, kick, symmetric clamp on the magnitude
	always_comb begin
		q = prod_s6[PROD_W-1:K_SHIFT];
		m = zero_s6 ? '0 : M_W'(q) + M_W'(cfg.kick);
		clip_d = (m > M_W'(cfg.vmax));
		drv_mag = {1'b0, mag_s7};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			done <= v_s7;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		neg_s5 <= sum_s4.s[S_W-1];
		zero_s5 <= (sum_s4.s == '0);
		dz_s5 <= sum_s4.dz;
		n1_s5 <= num[NUM_W-1:DEN_SHIFT];

		// divide by 625 through the reciprocal
		prod_s6 <= PROD_W'(n1_s5) * PROD_W'(RECIP);
		neg_s6 <= neg_s5;
		zero_s6 <= zero_s5;
		dz_s6 <= dz_s5;

		mag_s7 <= clip_d ? cfg.vmax : m[REG_W-1:0];
		clip_s7 <= clip_d;
		neg_s7 <= neg_s6;
		dz_s7 <= dz_s6;

		// drive opposes the sum; deadzone forces zero
		if (dz_s7) begin
			result.drive_voltage <= '0;
			result.clipped <= 1'b0;
		end else begin
			result.drive_voltage <= neg_s7 ? drv_mag : DRV_W'(-drv_mag);
			result.clipped <= clip_s7;
		end
	end

	`FSLD_ASSERT_NXT(a_zero_no_kick, clk, arst_n, v_s6 && zero_s6, (mag_s7 == '0) && !clip_s7)
	`FSLD_ASSERT_NXT(a_no_drop, clk, arst_n, v_s7, done)
	`FSLD_ASSERT_IMP(a_no_extra, clk, arst_n, done, $past(v_s7))

endmodule

// ----- rtl/fuzzy_scheduled_lqr_drive.sv -----
// Top level of the fuzzy gain-scheduled LQR drive: config registers and pipeline.
// Depends on fsld_pkg, fsld_sched, fsld_sum and fsld_out.
//
//  channel   handshake                  word
//  --------  -------------------------  ---------------------------------
//  sample    start, busy (always low)   sample_t: angle and four states
//  result    done strobe, one cycle     result_t: drive_voltage, clipped
//  config    cfg_valid, cfg_ready       cfg_index, cfg_data (12 bits)
//
// One sample enters every cycle; its result leaves on done.
// The pipeline is seven stages plus the output register; among them are the tilt-gain
// multiply, the 38-bit sum and the reciprocal divide.
// Reset clears valid bits and loads the config reset values; no clearing pass.
// The receiver cannot stall, so nothing ever holds the pipeline.
module fuzzy_scheduled_lqr_drive
	import fsld_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  sample_t              sample,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	cfg_t   cfg_q;
	logic   v_s2, v_s4;
	sched_t sched_s2;
	sum_t   sum_s4;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// config registers; unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kick <= KICK_RST;
			cfg_q.vmax <= VMAX_RST;
			cfg_q.dzone <= DZONE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KICK: cfg_q.kick <= cfg_data;
				CFG_VMAX: cfg_q.vmax <= cfg_data;
				CFG_DZONE: cfg_q.dzone <= cfg_data;
				default: ;
			endcase
		end
	end

	fsld_sched u_sched (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start && !busy),
		.sample   (sample),
		.v_s2     (v_s2),
		.sched_s2 (sched_s2)
	);

	fsld_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.v_s2     (v_s2),
		.sched_s2 (sched_s2),
		.v_s4     (v_s4),
		.sum_s4   (sum_s4)
	);

	fsld_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.v_s4   (v_s4),
		.sum_s4 (sum_s4),
		.done   (done),
		.result (result)
	);

endmodule

// ----- verif/fsld_drive_check.sv -----
`timescale 1ns / 1ps
// Scoreboard for the fuzzy scheduled LQR drive: shadows the config registers,
// predicts one drive word per accepted sample and checks results in order.
// Depends on fsld_pkg for the port types and register indexes.
module fsld_drive_check
	import fsld_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  sample_t              sample,
	input  logic                 done,
	input  result_t              result,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	output int                   errors,
	output int                   pending
);

	// pi/180 in Q30
	localparam longint PI_OVER_180_Q30 = 64'sd18740330;
	localparam int SHOW_MAX = 10;

	logic [REG_W-1:0] kick_sh;
	logic [REG_W-1:0] vmax_sh;
	logic [REG_W-1:0] dzone_sh;
	result_t          drive_q[$];
	result_t          want;
	int               err_cnt = 0;
	int               pend_cnt = 0;

	assign errors = err_cnt;
	assign pending = pend_cnt;

	// drive word for one sample under the given register settings
	function automatic result_t predict_drive(input sample_t w, input logic [REG_W-1:0] kick,
			input logic [REG_W-1:0] vmax, input logic [REG_W-1:0] dzone);
		longint  ang, tilt, rate, pos, vel, one;
		longint  w_lo, w_md, w_hi;
		longint  tgt_den, tgt, err, gain, acc, den, mag, q, drv, lim;
		logic    clip;
		result_t r;
		ang = longint'(w.servo_angle);
		tilt = $signed(w.tilt);
		rate = $signed(w.tilt_rate);
		pos = $signed(w.position);
		vel = $signed(w.velocity);
		one = longint'(1) <<< F;
		w_lo = 0;
		w_md = 0;
		w_hi = 0;
		// triangular memberships, in twentieths
		if (ang <= longint'(BP_LOW)) begin
			w_lo = 20;
		end else if (ang <= longint'(BP_MID)) begin
			w_lo = longint'(BP_MID) - ang;
			w_md = ang - longint'(BP_LOW);
		end else if (ang <= longint'(BP_HIGH)) begin
			w_md = longint'(BP_HIGH) - ang;
			w_hi = ang - longint'(BP_MID);
		end else begin
			w_hi = 20;
		end
		// scheduled target tilt, degrees*40 -> state format, nearest
		tgt_den = longint'(40) <<< 30;
		tgt = ((25 * w_lo + 26 * w_md + 25 * w_hi) * PI_OVER_180_Q30 * one + tgt_den / 2)
			/ tgt_den;
		err = tilt - tgt;
		// exact sum over 20000 * 2^F; only the high set has rate/pos/vel gains
		gain = 50 * w_lo + 60 * w_md + 70 * w_hi;
		acc = 1000 * gain * err + w_hi * (3000 * rate + 90 * one + 100 * pos + 1000 * vel);
		den = 20000 * one;
		mag = (acc < 0) ? -acc : acc;
		q = (mag * 256 + den / 2) / den;
		// drive opposes the sum, kick follows the sign of the exact sum
		drv = 0;
		if (acc < 0)
			drv = q + longint'(kick);
		else if (acc > 0)
			drv = -q - longint'(kick);
		lim = longint'(vmax);
		clip = 1'b0;
		if (drv > lim) begin
			drv = lim;
			clip = 1'b1;
		end else if (drv < -lim) begin
			drv = -lim;
			clip = 1'b1;
		end
		if (((err < 0) ? -err : err) < longint'(dzone)) begin
			drv = 0;
			clip = 1'b0;
		end
		r.drive_voltage = drv[DRV_W-1:0];
		r.clipped = clip;
		return r;
	endfunction

	// compare on done, predict on accept, shadow config writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kick_sh <= KICK_RST;
			vmax_sh <= VMAX_RST;
			dzone_sh <= DZONE_RST;
			drive_q.delete();
			pend_cnt = 0;
		end else begin
			if (done) begin
				if (drive_q.size() == 0) begin
					if (err_cnt < SHOW_MAX)
						$display("%0t: drive word with none pending: drive %0d clipped %0b",
							$time, $signed(result.drive_voltage), result.clipped);
					err_cnt++;
				end else begin
					want = drive_q.pop_front();
					if (result.drive_voltage !== want.drive_voltage ||
							result.clipped !== want.clipped) begin
						if (err_cnt < SHOW_MAX)
							$display("%0t: drive mismatch: exp drive %0d clipped %0b, got drive %0d clipped %0b",
								$time, $signed(want.drive_voltage), want.clipped,
								$signed(result.drive_voltage), result.clipped);
						err_cnt++;
					end
				end
			end
			if (start && !busy)
				drive_q.push_back(predict_drive(sample, kick_sh, vmax_sh, dzone_sh));
			pend_cnt = drive_q.size();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_KICK:  kick_sh <= cfg_data;
					CFG_VMAX:  vmax_sh <= cfg_data;
					CFG_DZONE: dzone_sh <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- verif/fuzzy_scheduled_lqr_drive_tb.sv -----
`timescale 1ns / 1ps
// Top of the fuzzy scheduled LQR drive bench: clock, reset, directed and random
// samples in bursts, register sweeps between phases. Uses fsld_pkg, fsld_drive_check.
module fuzzy_scheduled_lqr_drive_tb;
	import fsld_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RAND_ITEMS = 1150;
	localparam int PHASES = 8;
	localparam int TAIL = 16;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	sample_t              sample;
	logic                 done;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;
	int                   errors;
	int                   pending;
	int                   cycle_cnt = 0;
	int                   sent_cnt = 0;
	int                   burst_cnt = 0;
	int                   wr_cnt = 0;

	fuzzy_scheduled_lqr_drive dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample    (sample),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fsld_drive_check score (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample    (sample),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("fuzzy_scheduled_lqr_drive_tb: done, errors");
			$finish;
		end
	end

	function automatic sample_t mk_sample(input logic [7:0] ang, input int t, input int r,
			input int p, input int v);
		sample_t w;
		w.servo_angle = ang;
		w.tilt = 16'(t);
		w.tilt_rate = 16'(r);
		w.position = 16'(p);
		w.velocity = 16'(v);
		return w;
	endfunction

	// mostly small states, some full-scale and some full random
	function automatic logic [15:0] rand_state();
		logic [15:0] x;
		case ($urandom_range(0, 9))
			0, 1, 2: x = 16'($urandom);
			3: begin
				case ($urandom_range(0, 3))
					0: x = 16'h8000;
					1: x = 16'h7fff;
					2: x = 16'hffff;
					default: x = 16'h0000;
				endcase
			end
			default: x = 16'($urandom_range(0, 4095) - 2048);
		endcase
		return x;
	endfunction

	// hold start and the word until accepted
	task automatic send(input sample_t w);
		logic take;
		start <= 1'b1;
		sample <= w;
		do begin
			@(negedge clk);
			take = !busy;
			@(posedge clk);
		end while (!take);
		sent_cnt++;
	endtask

	task automatic idle(input int n);
		start <= 1'b0;
		sample <= {8'($urandom), $urandom, $urandom};
		repeat (n) @(posedge clk);
	endtask

	// stop sending and wait for every pending result
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// leaves cfg_valid high; apply_cfg drops it after the last word
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		logic take;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(negedge clk);
			take = cfg_ready;
			@(posedge clk);
		end while (!take);
		wr_cnt++;
	endtask

	task automatic apply_cfg(input logic [REG_W-1:0] k, input logic [REG_W-1:0] v,
			input logic [REG_W-1:0] dz);
		write_reg(CFG_KICK, k);
		write_reg(CFG_VMAX, v);
		write_reg(CFG_DZONE, dz);
		write_reg(CFG_SPARE, 12'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		sample_t          w;
		int               left;
		int               burst;
		int               gap;
		logic [REG_W-1:0] k;
		logic [REG_W-1:0] v;
		logic [REG_W-1:0] dz;
		arst_n <= 1'b0;
		start <= 1'b0;
		sample <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_KICK;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings: angle corners, field extremes, deadzone
		send(mk_sample(8'd0, 0, 0, 0, 0));
		send(mk_sample(8'd100, 894, 0, 0, 0));
		send(mk_sample(8'd115, 32767, 32767, 32767, 32767));
		send(mk_sample(8'd116, -32768, -32768, -32768, -32768));
		send(mk_sample(8'd125, 930, 0, 0, 0));
		send(mk_sample(8'd135, 929, 0, 0, 0));
		send(mk_sample(8'd136, 1000, 32767, -32768, 0));
		send(mk_sample(8'd145, -32768, 32767, -32768, 32767));
		send(mk_sample(8'd155, 950, -32768, 32767, -32768));
		send(mk_sample(8'd156, 32767, -32768, 32767, -32768));
		send(mk_sample(8'd180, 800, 100, -100, 50));
		send(mk_sample(8'd181, 894, 0, 0, 0));
		send(mk_sample(8'd255, -32768, 0, 0, 0));
		send(mk_sample(8'd170, 910, -123, 0, 0));
		send(mk_sample(8'd160, 920, 0, 0, 0));
		drain();

		// deadzone off: on-target tilt with no high-set weight sums to exactly zero; also off-target and high-set samples
		apply_cfg(KICK_RST, VMAX_RST, 12'd0);
		send(mk_sample(8'd100, 894, 0, 0, 0));
		send(mk_sample(8'd135, 929, 0, 0, 0));
		send(mk_sample(8'd120, 895, 0, 0, 0));
		send(mk_sample(8'd130, 893, 0, 0, 0));
		send(mk_sample(8'd180, 894, -1, 0, 0));
		send(mk_sample(8'd90, 894, 32767, -32768, 32767));
		drain();

		// random phases, each under its own register setting
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin k = KICK_RST; v = VMAX_RST; dz = DZONE_RST; end
				1: begin k = 12'd0; v = 12'd0; dz = 12'd0; end
				2: begin k = 12'hfff; v = 12'hfff; dz = 12'hfff; end
				3: begin k = 12'd0; v = 12'd2560; dz = 12'd0; end
				4: begin k = 12'd2560; v = 12'd2560; dz = 12'd1; end
				5: begin k = 12'd300; v = 12'd600; dz = 12'd40; end
				default: begin
					k = 12'($urandom_range(0, 2560));
					v = 12'($urandom_range(0, 2560));
					dz = 12'($urandom_range(0, 120));
				end
			endcase
			apply_cfg(k, v, dz);
			left = RAND_ITEMS / PHASES;
			while (left > 0) begin
				burst = $urandom_range(1, 48);
				if (burst > left)
					burst = left;
				burst_cnt++;
				repeat (burst) begin
					// angles cluster on the schedule, with corners and over-range
					case ($urandom_range(0, 9))
						0: begin
							case ($urandom_range(0, 3))
								0: w.servo_angle = BP_LOW;
								1: w.servo_angle = BP_MID;
								2: w.servo_angle = BP_HIGH;
								default: w.servo_angle = 8'd180;
							endcase
							w.servo_angle = w.servo_angle + 8'($urandom_range(0, 2)) - 8'd1;
						end
						1: w.servo_angle = 8'($urandom);
						default: w.servo_angle = 8'($urandom_range(100, 170));
					endcase
					// half the tilts land near the target to work the deadzone edge
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: w.tilt = 16'($urandom_range(840, 980));
						5, 6, 7: w.tilt = 16'($urandom_range(0, 8191) - 4096);
						default: w.tilt = 16'($urandom);
					endcase
					w.tilt_rate = rand_state();
					w.position = rand_state();
					w.velocity = rand_state();
					send(w);
				end
				left -= burst;
				case ($urandom_range(0, 9))
					0, 1, 2, 3: gap = 0;
					9: gap = $urandom_range(8, 20);
					default: gap = $urandom_range(1, 4);
				endcase
				if (gap > 0)
					idle(gap);
			end
			drain();
		end

		repeat (TAIL) @(posedge clk);
		$display("drive run: %0d samples, %0d random bursts, %0d register words",
			sent_cnt, burst_cnt, wr_cnt);
		$display("settings swept: reset values, all zero, all full-scale, %0d more", PHASES - 3);
		if (errors == 0)
			$display("fuzzy_scheduled_lqr_drive_tb: done, clean");
		else
			$display("fuzzy_scheduled_lqr_drive_tb: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/fsld_pkg.sv
rtl/fsld_sched.sv
rtl/fsld_sum.sv
rtl/fsld_out.sv
rtl/fuzzy_scheduled_lqr_drive.sv
verif/fsld_drive_check.sv
verif/fuzzy_scheduled_lqr_drive_tb.sv
